### rtl/core/tga_rle_pkg.sv
// Shared types and constants for the Targa run-length row encoder.
// Used by tga_rle_ctrl, tga_rle_dpath and tga_rle_row_encoder_core.
package tga_rle_pkg;

   localparam int MAX_SPAN_DEF       = 128;
   localparam int PIX_PER_RESULT_DEF = 4;
   localparam int PIX_FIELDS         = 4;
   localparam int PIX_IDX_W          = 2;
   localparam int PIX_W              = 32;
   localparam int COUNT_W            = 3;
   localparam int HDR_CNT_W          = 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GATHER,
      ST_EMIT,
      ST_COPY,
      ST_WRITE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic gather;
      logic load_out;
      logic write_copy;
      logic write_pix;
   } ctrl_cmd_type;

   typedef struct packed {
      logic dec_send;
      logic chunk_done;
      logic out_free;
      logic final_chunk;
      logic end_phase;
      logic copy_pending;
      logic row_end;
   } dp_status_type;

endpackage

### rtl/core/tga_rle_ctrl.sv
// Sequencer for the run-length encoder: steps each pixel through span send,
// predecessor copy, store write and row-end flush. Depends on tga_rle_pkg.
module tga_rle_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tga_rle_pkg::dp_status_type status,
   output tga_rle_pkg::ctrl_cmd_type  cmd
);
   import tga_rle_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.dec_send ? ST_GATHER : ST_WRITE;
            end
         end
         ST_GATHER: begin
            if (status.chunk_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (!status.final_chunk) begin
                  state_in = ST_GATHER;
               end else if (status.end_phase) begin
                  state_in = ST_IDLE;
               end else if (status.copy_pending) begin
                  state_in = ST_COPY;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_COPY: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = status.row_end ? ST_GATHER : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_GATHER: begin
            cmd.gather = 1'b1;
         end
         ST_EMIT: begin
            cmd.load_out = status.out_free;
         end
         ST_COPY: begin
            cmd.write_copy = 1'b1;
         end
         ST_WRITE: begin
            cmd.write_pix = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/core/tga_rle_dpath.sv
// Datapath of the run-length encoder: span state, pixel store, chunk gather
// and the result register. Depends on tga_rle_pkg; driven by tga_rle_ctrl.
module tga_rle_dpath #(
   parameter int MAX_SPAN          = tga_rle_pkg::MAX_SPAN_DEF,
   parameter int PIXELS_PER_RESULT = tga_rle_pkg::PIX_PER_RESULT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tga_rle_pkg::ctrl_cmd_type  cmd,
   output tga_rle_pkg::dp_status_type status,
   input  logic                       csr_valid,
   input  logic                       csr_alpha_enabled,
   input  logic [7:0]                 req_red,
   input  logic [7:0]                 req_green,
   input  logic [7:0]                 req_blue,
   input  logic [7:0]                 req_alpha,
   input  logic                       req_row_end,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_header_valid,
   output logic [7:0]                 rsp_header_byte,
   output logic [2:0]                 rsp_pixel_count,
   output logic [31:0]                rsp_pixel_0,
   output logic [31:0]                rsp_pixel_1,
   output logic [31:0]                rsp_pixel_2,
   output logic [31:0]                rsp_pixel_3,
   output logic                       rsp_last
);
   import tga_rle_pkg::*;

   localparam int LW    = $clog2(MAX_SPAN + 1);
   localparam int AW    = $clog2(MAX_SPAN);
   localparam int CMPW  = LW + COUNT_W;
   localparam int CHUNK = (PIXELS_PER_RESULT > PIX_FIELDS) ? PIX_FIELDS : PIXELS_PER_RESULT;

   logic              alpha_en_ff;
   logic [LW-1:0]     len_ff, len_in;
   logic              rep_ff, rep_in;
   logic [PIX_W-1:0]  prev_ff, prev_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic              row_end_ff, row_end_in;
   logic              copy_ff, copy_in;
   logic              snd_rep_ff, snd_rep_in;
   logic [LW-1:0]     snd_n_ff, snd_n_in;
   logic [LW-1:0]     snd_total_ff, snd_total_in;
   logic [LW-1:0]     snd_pos_ff, snd_pos_in;
   logic              snd_first_ff, snd_first_in;
   logic              end_phase_ff, end_phase_in;
   logic [COUNT_W-1:0] iss_ff, iss_in;
   logic [COUNT_W-1:0] cap_ff, cap_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [PIX_W-1:0]  rdata_ff;
   logic [PIX_W-1:0]  stage_ff [PIX_FIELDS];
   logic [PIX_W-1:0]  mem [MAX_SPAN];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_header_valid_ff;
   logic [7:0]        rsp_header_byte_ff;
   logic [COUNT_W-1:0] rsp_pixel_count_ff;
   logic [PIX_W-1:0]  rsp_pixel_ff [PIX_FIELDS];
   logic              rsp_last_ff;

   logic [PIX_W-1:0]  req_pix;
   logic [PIX_W-1:0]  cmp_mask;
   logic              same;
   logic              len_nz, len_one, at_max;
   logic              act_split, act_close, act_limit;
   logic [LW-1:0]     remain;
   logic [COUNT_W-1:0] take;
   logic              final_chunk;
   logic              issue;
   logic [LW-1:0]     rd_sum;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [PIX_W-1:0]  mem_wd;

   assign req_pix  = {(alpha_en_ff ? req_alpha : 8'h00), req_blue, req_green, req_red};
   assign cmp_mask = alpha_en_ff ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
   assign same     = ((req_pix ^ prev_ff) & cmp_mask) == '0;
   assign len_nz   = len_ff != '0;
   assign len_one  = len_ff == LW'(1);
   assign at_max   = len_ff >= LW'(MAX_SPAN);

   assign act_split = len_nz && !len_one && same && !rep_ff;
   assign act_close = len_nz && !len_one && !same && rep_ff;
   assign act_limit = len_nz && !len_one && (same == rep_ff) && at_max;

   assign remain      = snd_total_ff - snd_pos_ff;
   assign take        = (CMPW'(remain) > CMPW'(CHUNK)) ? COUNT_W'(CHUNK) : COUNT_W'(remain);
   assign final_chunk = (CMPW'(snd_pos_ff) + CMPW'(take)) >= CMPW'(snd_total_ff);

   assign issue   = cmd.gather && (iss_ff < take);
   assign rd_sum  = snd_pos_ff + LW'(iss_ff);
   assign rd_addr = rd_sum[AW-1:0];

   assign mem_we = cmd.write_copy || cmd.write_pix;
   assign mem_wa = cmd.write_copy ? '0 : len_ff[AW-1:0];
   assign mem_wd = cmd.write_copy ? prev_ff : pix_ff;

   always_comb begin
      status.dec_send     = act_split || act_close || act_limit;
      status.chunk_done   = cap_ff == take;
      status.out_free     = !rsp_valid_ff || rsp_ready;
      status.final_chunk  = final_chunk;
      status.end_phase    = end_phase_ff;
      status.copy_pending = copy_ff;
      status.row_end      = row_end_ff;
   end

   always_comb begin
      len_in       = len_ff;
      rep_in       = rep_ff;
      prev_in      = prev_ff;
      pix_in       = pix_ff;
      row_end_in   = row_end_ff;
      copy_in      = copy_ff;
      snd_rep_in   = snd_rep_ff;
      snd_n_in     = snd_n_ff;
      snd_total_in = snd_total_ff;
      snd_pos_in   = snd_pos_ff;
      snd_first_in = snd_first_ff;
      end_phase_in = end_phase_ff;
      if (cmd.accept) begin
         pix_in       = req_pix;
         row_end_in   = req_row_end;
         copy_in      = act_split;
         end_phase_in = 1'b0;
         snd_pos_in   = '0;
         snd_first_in = 1'b1;
         if (len_one) begin
            rep_in = same;
         end
         if (act_split) begin
            // close the literal without its last pixel, which opens a repeat
            snd_rep_in   = 1'b0;
            snd_n_in     = len_ff - LW'(1);
            snd_total_in = len_ff - LW'(1);
            len_in       = LW'(1);
            rep_in       = 1'b1;
         end else if (act_close) begin
            snd_rep_in   = 1'b1;
            snd_n_in     = len_ff;
            snd_total_in = LW'(1);
            len_in       = '0;
            rep_in       = 1'b0;
         end else if (act_limit) begin
            snd_rep_in   = rep_ff;
            snd_n_in     = len_ff;
            snd_total_in = rep_ff ? LW'(1) : len_ff;
            len_in       = '0;
         end
      end
      if (cmd.write_copy) begin
         copy_in = 1'b0;
      end
      if (cmd.write_pix) begin
         prev_in = pix_ff;
         len_in  = len_ff + LW'(1);
         if (row_end_ff) begin
            snd_rep_in   = rep_ff;
            snd_n_in     = len_ff + LW'(1);
            snd_total_in = rep_ff ? LW'(1) : len_ff + LW'(1);
            snd_pos_in   = '0;
            snd_first_in = 1'b1;
            end_phase_in = 1'b1;
            len_in       = '0;
            rep_in       = 1'b0;
         end
      end
      if (cmd.load_out) begin
         snd_pos_in   = snd_pos_ff + LW'(take);
         snd_first_in = 1'b0;
      end
   end

   always_comb begin
      iss_in    = iss_ff;
      cap_in    = cap_ff;
      rd_vld_in = issue;
      if (cmd.accept || cmd.load_out || cmd.write_pix) begin
         iss_in    = '0;
         cap_in    = '0;
         rd_vld_in = 1'b0;
      end else begin
         if (issue) begin
            iss_in = iss_ff + COUNT_W'(1);
         end
         if (rd_vld_ff) begin
            cap_in = cap_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_en_ff  <= 1'b0;
         len_ff       <= '0;
         rep_ff       <= 1'b0;
         prev_ff      <= '0;
         row_end_ff   <= 1'b0;
         copy_ff      <= 1'b0;
         end_phase_ff <= 1'b0;
         snd_first_ff <= 1'b0;
         iss_ff       <= '0;
         cap_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            alpha_en_ff <= csr_alpha_enabled;
         end
         len_ff       <= len_in;
         rep_ff       <= rep_in;
         prev_ff      <= prev_in;
         row_end_ff   <= row_end_in;
         copy_ff      <= copy_in;
         end_phase_ff <= end_phase_in;
         snd_first_ff <= snd_first_in;
         iss_ff       <= iss_in;
         cap_ff       <= cap_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      snd_rep_ff   <= snd_rep_in;
      snd_n_ff     <= snd_n_in;
      snd_total_ff <= snd_total_in;
      snd_pos_ff   <= snd_pos_in;
      if (rd_vld_ff) begin
         stage_ff[cap_ff[PIX_IDX_W-1:0]] <= rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_header_valid_ff <= snd_first_ff;
         rsp_header_byte_ff  <= snd_first_ff ?
                                {snd_rep_ff, HDR_CNT_W'(snd_n_ff - LW'(1))} : 8'h00;
         rsp_pixel_count_ff  <= take;
         rsp_last_ff         <= final_chunk && (end_phase_ff || !row_end_ff);
         for (int k = 0; k < PIX_FIELDS; k++) begin
            rsp_pixel_ff[k] <= (COUNT_W'(k) < take) ? stage_ff[k] : '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_header_valid = rsp_header_valid_ff;
   assign rsp_header_byte  = rsp_header_byte_ff;
   assign rsp_pixel_count  = rsp_pixel_count_ff;
   assign rsp_pixel_0      = rsp_pixel_ff[0];
   assign rsp_pixel_1      = rsp_pixel_ff[1];
   assign rsp_pixel_2      = rsp_pixel_ff[2];
   assign rsp_pixel_3      = rsp_pixel_ff[3];
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_len_max: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MAX_SPAN))
      else $error("span length beyond limit");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   a_gather_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rd_vld_ff)
      else $error("result loaded with a store read in flight");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pixel_count_ff != '0 && rsp_pixel_count_ff <= COUNT_W'(CHUNK)))
      else $error("pixel count out of range");

   a_repeat_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_header_valid_ff && rsp_header_byte_ff[7])
      |-> rsp_pixel_count_ff == COUNT_W'(1))
      else $error("repeat span carries more than one pixel");
`endif

endmodule

### rtl/core/tga_rle_row_encoder_core.sv
// Targa run-length row encoder: one pixel per req beat, one span piece per
// rsp beat. A pixel that closes no span is accepted and then written to the
// span store; a pixel that splits a literal span also has its predecessor
// moved to the first store entry. The pixels of each rsp beat are gathered
// through the single read port of the span store, which yields one pixel a
// cycle. A repeat span is one beat; a literal span of n pixels is
// ceil(n/4) beats. The finished beat waits in an output register, so the
// next req beat is taken while it is pending. The span store is not cleared
// after reset; only entries of the open span are ever read.
// Depends on tga_rle_pkg, tga_rle_ctrl and tga_rle_dpath.
module tga_rle_row_encoder_core #(
   parameter int MAX_SPAN          = tga_rle_pkg::MAX_SPAN_DEF,
   parameter int PIXELS_PER_RESULT = tga_rle_pkg::PIX_PER_RESULT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_alpha_enabled,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   input  logic        req_row_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_header_valid,
   output logic [7:0]  rsp_header_byte,
   output logic [2:0]  rsp_pixel_count,
   output logic [31:0] rsp_pixel_0,
   output logic [31:0] rsp_pixel_1,
   output logic [31:0] rsp_pixel_2,
   output logic [31:0] rsp_pixel_3,
   output logic        rsp_last
);
   import tga_rle_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   tga_rle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tga_rle_dpath #(
      .MAX_SPAN          (MAX_SPAN),
      .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_alpha_enabled (csr_alpha_enabled),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_alpha         (req_alpha),
      .req_row_end       (req_row_end),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_header_valid  (rsp_header_valid),
      .rsp_header_byte   (rsp_header_byte),
      .rsp_pixel_count   (rsp_pixel_count),
      .rsp_pixel_0       (rsp_pixel_0),
      .rsp_pixel_1       (rsp_pixel_1),
      .rsp_pixel_2       (rsp_pixel_2),
      .rsp_pixel_3       (rsp_pixel_3),
      .rsp_last          (rsp_last)
   );

endmodule

### tb/tb_tga_rle_row_encoder_core.sv
// Self-checking testbench for tga_rle_row_encoder_core: drives pixel beats, config writes
// and rsp back-pressure, and checks every rsp beat against an in-bench span encoder.
// Depends on tga_rle_pkg and tga_rle_row_encoder_core.
module tb_tga_rle_row_encoder_core;
   timeunit 1ns;
   timeprecision 1ps;
   import tga_rle_pkg::*;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic                  header_valid;
      logic [7:0]            header_byte;
      logic [COUNT_W-1:0]    pix_cnt;
      logic [3:0][PIX_W-1:0] pixel;
      logic                  last;
   } rle_beat_type;

   typedef enum int {SEG_RUN, SEG_LITERAL, SEG_NOISE} seg_kind_type;

   class rle_scoreboard_type;
      localparam int CHUNK = (PIX_PER_RESULT_DEF > PIX_FIELDS) ? PIX_FIELDS
                                                                 : PIX_PER_RESULT_DEF;
      bit [31:0]    span_pix [128];
      int unsigned  open_len;
      bit           span_rep;
      bit [31:0]    prev_pix;
      bit           alpha_en;
      rle_beat_type pending [$];
      int           errors;

      function void set_alpha(bit en);
         alpha_en = en;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function void emit_span(bit rep, int unsigned n);
         int unsigned  total;
         int unsigned  pos;
         int unsigned  take;
         bit           first;
         rle_beat_type b;
         total = rep ? 1 : n;
         pos   = 0;
         first = 1'b1;
         do begin
            b    = '0;
            take = total - pos;
            if (take > CHUNK) take = CHUNK;
            if (first) begin
               b.header_valid = 1'b1;
               b.header_byte  = {rep, 7'(n - 1)};
            end
            b.pix_cnt = COUNT_W'(take);
            for (int j = 0; j < take; j++) b.pixel[j] = span_pix[(pos + j) % 128];
            pos   += take;
            first  = 1'b0;
            pending.push_back(b);
         end while (pos < total);
      endfunction

      function void note_pixel(pixel_type px, bit row_end);
         bit [31:0]    p;
         bit [31:0]    mask;
         bit           same;
         int           base_cnt;
         rle_beat_type b;
         p = px;
         if (!alpha_en) p[31:24] = 8'h00;
         mask     = alpha_en ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
         base_cnt = pending.size();
         if (open_len != 0) begin
            same = ((p ^ prev_pix) & mask) == 0;
            if (open_len == 1) begin
               span_rep = same;
            end else if (same != span_rep) begin
               if (same) begin
                  emit_span(1'b0, open_len - 1);
                  span_pix[0] = span_pix[(open_len - 1) % 128];
                  open_len    = 1;
                  span_rep    = 1'b1;
               end else begin
                  emit_span(1'b1, open_len);
                  open_len = 0;
                  span_rep = 1'b0;
               end
            end else if (open_len >= MAX_SPAN_DEF) begin
               emit_span(span_rep, open_len);
               open_len = 0;
            end
         end
         span_pix[open_len % 128] = p;
         open_len++;
         prev_pix = p;
         if (row_end) begin
            emit_span(span_rep, open_len);
            open_len = 0;
            span_rep = 1'b0;
         end
         if (pending.size() > base_cnt) begin
            b      = pending.pop_back();
            b.last = 1'b1;
            pending.push_back(b);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_beat(rle_beat_type got);
         rle_beat_type want;
         if (pending.size() == 0) begin
            $error("unexpected rsp beat: header_byte %0h pixel count %0d",
                   got.header_byte, got.pix_cnt);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("header_valid", want.header_valid, got.header_valid);
         compare_field("header_byte", want.header_byte, got.header_byte);
         compare_field("rsp_pixel_count", want.pix_cnt, got.pix_cnt);
         for (int j = 0; j < 4; j++)
            compare_field($sformatf("pixel_%0d", j), want.pixel[j], got.pixel[j]);
         compare_field("last", want.last, got.last);
      endfunction

      function int finish_check();
         if (pending.size() != 0) begin
            $error("%0d rsp beats never arrived", pending.size());
            errors++;
         end
         return errors;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_alpha_enabled = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic [7:0]  req_alpha = '0;
   logic        req_row_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_header_valid;
   logic [7:0]  rsp_header_byte;
   logic [2:0]  rsp_pixel_count;
   logic [31:0] rsp_pixel_0;
   logic [31:0] rsp_pixel_1;
   logic [31:0] rsp_pixel_2;
   logic [31:0] rsp_pixel_3;
   logic        rsp_last;

   rle_scoreboard_type sb = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles   = 0;
   int items_sent    = 0;

   tga_rle_row_encoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_alpha_enabled (csr_alpha_enabled),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_alpha         (req_alpha),
      .req_row_end       (req_row_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_header_valid  (rsp_header_valid),
      .rsp_header_byte   (rsp_header_byte),
      .rsp_pixel_count   (rsp_pixel_count),
      .rsp_pixel_0       (rsp_pixel_0),
      .rsp_pixel_1       (rsp_pixel_1),
      .rsp_pixel_2       (rsp_pixel_2),
      .rsp_pixel_3       (rsp_pixel_3),
      .rsp_last          (rsp_last)
   );

   always #5 clock = ~clock;

   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rle_beat_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.header_valid = rsp_header_valid;
         got.header_byte  = rsp_header_byte;
         got.pix_cnt      = rsp_pixel_count;
         got.pixel        = {rsp_pixel_3, rsp_pixel_2, rsp_pixel_1, rsp_pixel_0};
         got.last         = rsp_last;
         sb.check_beat(got);
      end
   end

   function automatic pixel_type make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a);
      return '{alpha: a, blue: b, green: g, red: r};
   endfunction

   // Entered and left at a falling edge; valid stays high when the next beat follows.
   task automatic send_pixel(pixel_type p, bit row_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_red     <= p.red;
      req_green   <= p.green;
      req_blue    <= p.blue;
      req_alpha   <= p.alpha;
      req_row_end <= row_end;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(p, row_end);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_alpha(bit en);
      csr_alpha_enabled <= en;
      csr_valid         <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_alpha(en);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, drain all expected beats, then let the store write settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_segment(seg_kind_type kind, int len, bit end_row);
      pixel_type base;
      pixel_type prev;
      pixel_type p;
      pixel_type palette [3];
      bit        re;
      base = $urandom;
      prev = base;
      for (int k = 0; k < 3; k++) palette[k] = $urandom;
      for (int i = 0; i < len; i++) begin
         case (kind)
            SEG_RUN: begin
               p = base;
            end
            SEG_LITERAL: begin
               p = $urandom;
               if (p[23:0] == prev[23:0]) p.red = ~p.red;
            end
            default: begin
               p = palette[$urandom_range(2)];
               if ($urandom_range(1)) p.alpha = $urandom;
            end
         endcase
         prev = p;
         re   = (i == len - 1) ? end_row : (len < 16 && $urandom_range(49) == 0);
         send_pixel(p, re);
      end
   endtask

   task automatic run_phase(int n_items, seg_kind_type long_kind, int long_len,
                            bit long_end);
      int start;
      start = items_sent;
      send_segment(long_kind, long_len, long_end);
      while (items_sent - start < n_items)
         send_segment(seg_kind_type'($urandom_range(2)), $urandom_range(1, 12),
                      $urandom_range(9) < 4);
   endtask

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // alpha disabled from reset
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1);
      send_pixel(make_pixel(8'h11, 8'h22, 8'h33, 8'h00), 1'b0);
      send_pixel(make_pixel(8'h44, 8'h55, 8'h66, 8'h00), 1'b0);
      send_pixel(make_pixel(8'h77, 8'h88, 8'h99, 8'h00), 1'b0);
      send_pixel(make_pixel(8'h77, 8'h88, 8'h99, 8'h00), 1'b0);
      send_pixel(make_pixel(8'h77, 8'h88, 8'h99, 8'h00), 1'b1);
      send_pixel(make_pixel(8'hAA, 8'hBB, 8'hCC, 8'h00), 1'b0);
      send_pixel(make_pixel(8'hAA, 8'hBB, 8'hCC, 8'h00), 1'b0);
      send_pixel(make_pixel(8'h01, 8'h02, 8'h03, 8'h00), 1'b1);
      for (int i = 0; i < 6; i++)
         send_pixel(make_pixel(8'(i * 40 + 1), 8'(255 - i), 8'(i << 5), 8'hA5), i == 5);
      send_pixel(make_pixel(8'h5A, 8'h5A, 8'h5A, 8'h01), 1'b0);
      send_pixel(make_pixel(8'h5A, 8'h5A, 8'h5A, 8'h02), 1'b1);
      wait_idle();
      write_alpha(1'b1);
      send_pixel(make_pixel(8'h80, 8'h40, 8'h20, 8'h00), 1'b0);
      send_pixel(make_pixel(8'h80, 8'h40, 8'h20, 8'hFF), 1'b0);
      send_pixel(make_pixel(8'h80, 8'h40, 8'h20, 8'hFF), 1'b1);
      // hold a span open across an alpha change
      send_pixel(make_pixel(8'h3C, 8'hC3, 8'h0F, 8'h80), 1'b0);
      wait_idle();
      write_alpha(1'b0);
      send_pixel(make_pixel(8'h3C, 8'hC3, 8'h0F, 8'h01), 1'b1);

      wait_idle();
      write_alpha(1'b1);
      hold_cycles = 400;
      run_phase(140, SEG_RUN, 129, 1'b1);

      wait_idle();
      write_alpha(1'b0);
      send_idle_pct = 88;
      run_phase(140, SEG_LITERAL, 130, 1'b0);

      wait_idle();
      write_alpha(1'b1);
      send_idle_pct = 0;
      rsp_stall_pct = 88;
      run_phase(80, SEG_NOISE, 0, 1'b0);

      wait_idle();
      write_alpha(1'b0);
      send_idle_pct = 36;
      rsp_stall_pct = 36;
      run_phase(80, SEG_NOISE, 0, 1'b0);

      wait_idle();
      repeat (32) @(posedge clock);
      if (sb.finish_check() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
